@@ src/fpd_pkg.sv @@
package fpd_pkg;

    // crc-16, polynomial 0x1021, msb first, zero seed
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // byte position within a buffer, saturating
    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(6);

    // header byte positions
    localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(4);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(5);

    localparam logic [7:0] START_MARKER_RESET = 8'd90;

    // output queue
    localparam int QUEUE_DEPTH = 3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_TOO_SHORT = 2'd2,
        ST_CRC_BAD   = 2'd3
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       item_kind;
        logic [7:0]  payload_byte;
        status_t     frame_status;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic        final_item;
    } item_t;

    // up to two result items produced by one accepted word
    typedef struct packed {
        logic [1:0] count;
        item_t      first;
        item_t      second;
    } push_t;

    // one byte step of the crc
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/fpd_frame_ctl.sv @@
module fpd_frame_ctl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [7:0]           rx_byte,
    input  logic                 buffer_end,
    input  logic [7:0]           start_marker,
    output fpd_pkg::push_t       push
);

    logic [fpd_pkg::POS_W-1:0] pos_reg, pos_next, idx;
    logic [7:0]  type_reg, type_upd, type_next;
    logic [15:0] len_reg, len_upd, len_next;
    logic [15:0] sent_reg, sent_upd, sent_next;
    logic [15:0] crc_reg, crc_upd, crc_next, crc_step;
    logic        given_reg, given_upd, given_next;
    logic        payload_hit, status_hit;
    fpd_pkg::status_t st;
    fpd_pkg::item_t   pay_item, st_item;

    assign crc_step = fpd_pkg::crc_byte(crc_reg, rx_byte);
    assign idx      = pos_reg - fpd_pkg::HEADER_BYTES;

    // header parse, crc and status decision for the incoming word
    always_comb begin
        type_upd    = type_reg;
        len_upd     = len_reg;
        sent_upd    = sent_reg;
        crc_upd     = crc_reg;
        payload_hit = 1'b0;
        status_hit  = 1'b0;
        st          = fpd_pkg::ST_OK;
        if (!given_reg) begin
            case (pos_reg)
                fpd_pkg::POS_START: begin
                    if (rx_byte != start_marker) begin
                        status_hit = 1'b1;
                        st         = fpd_pkg::ST_BAD_START;
                    end else begin
                        crc_upd = crc_step;
                    end
                end
                fpd_pkg::POS_TYPE: begin
                    type_upd = rx_byte;
                    crc_upd  = crc_step;
                end
                fpd_pkg::POS_LEN_LO: begin
                    len_upd = {8'h00, rx_byte};
                    crc_upd = crc_step;
                end
                fpd_pkg::POS_LEN_HI: begin
                    len_upd = {rx_byte, len_reg[7:0]};
                    crc_upd = crc_step;
                end
                fpd_pkg::POS_CRC_LO: begin
                    sent_upd = {8'h00, rx_byte};
                end
                fpd_pkg::POS_CRC_HI: begin
                    sent_upd = {rx_byte, sent_reg[7:0]};
                    if (len_reg == 16'h0000) begin
                        status_hit = 1'b1;
                        st = (crc_reg == sent_upd) ? fpd_pkg::ST_OK : fpd_pkg::ST_CRC_BAD;
                    end
                end
                default: begin
                    // payload region
                    if (idx < {1'b0, len_reg}) begin
                        crc_upd     = crc_step;
                        payload_hit = 1'b1;
                        if (idx + 1'b1 == {1'b0, len_reg}) begin
                            status_hit = 1'b1;
                            st = (crc_step == sent_reg) ? fpd_pkg::ST_OK
                                                        : fpd_pkg::ST_CRC_BAD;
                        end
                    end
                end
            endcase
        end
        given_upd = given_reg | status_hit;
        // buffer ended before any status
        if (buffer_end && !given_upd) begin
            status_hit = 1'b1;
            st         = fpd_pkg::ST_TOO_SHORT;
        end
    end

    // next state, cleared at the end of a buffer
    always_comb begin
        pos_next   = (pos_reg != fpd_pkg::POS_MAX) ? pos_reg + 1'b1 : pos_reg;
        type_next  = type_upd;
        len_next   = len_upd;
        sent_next  = sent_upd;
        crc_next   = crc_upd;
        given_next = given_upd;
        if (buffer_end) begin
            pos_next   = '0;
            type_next  = '0;
            len_next   = '0;
            sent_next  = '0;
            crc_next   = '0;
            given_next = 1'b0;
        end
    end

    // result items
    always_comb begin
        pay_item.item_kind    = fpd_pkg::KIND_PAYLOAD;
        pay_item.payload_byte = rx_byte;
        pay_item.frame_status = fpd_pkg::ST_OK;
        pay_item.frame_type   = type_upd;
        pay_item.frame_length = len_upd;
        pay_item.final_item   = 1'b0;

        st_item.item_kind     = fpd_pkg::KIND_STATUS;
        st_item.payload_byte  = 8'h00;
        st_item.frame_status  = st;
        st_item.frame_type    = type_upd;
        st_item.frame_length  = len_upd;
        st_item.final_item    = 1'b1;

        push.first  = payload_hit ? pay_item : st_item;
        push.second = st_item;
        push.count  = in_accept ? ({1'b0, payload_hit} + {1'b0, status_hit}) : 2'd0;
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            sent_reg  <= '0;
            crc_reg   <= '0;
            given_reg <= 1'b0;
        end else if (in_accept) begin
            pos_reg   <= pos_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            sent_reg  <= sent_next;
            crc_reg   <= crc_next;
            given_reg <= given_next;
        end
    end

endmodule

@@ src/fpd_out_queue.sv @@
module fpd_out_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  fpd_pkg::push_t push,
    input  logic           pop,
    output fpd_pkg::item_t head,
    output logic           head_valid,
    output logic           can_take
);

    localparam int IDX_W = $clog2(fpd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(fpd_pkg::QUEUE_DEPTH + 1);

    fpd_pkg::item_t   mem_reg [fpd_pkg::QUEUE_DEPTH];
    logic [IDX_W-1:0] wr_reg, wr_next, wr_second, rd_reg, rd_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(fpd_pkg::QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign head       = mem_reg[rd_reg];
    assign head_valid = (count_reg != '0);
    // room for two more words whatever the receiver does
    assign can_take   = (count_reg <= CNT_W'(fpd_pkg::QUEUE_DEPTH - 2));

    // pointer and fill updates
    always_comb begin
        wr_second  = next_idx(wr_reg);
        case (push.count)
            2'd0:    wr_next = wr_reg;
            2'd1:    wr_next = wr_second;
            default: wr_next = next_idx(wr_second);
        endcase
        rd_next    = pop ? next_idx(rd_reg) : rd_reg;
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_second] <= push.second;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ src/framed_packet_decoder_top.sv @@
// Framed packet decoder.
// Input stream (s_*): one received byte per word, s_tlast on the last byte of a
// buffer. A frame is start byte, type byte, 16-bit little-endian length, 16-bit
// little-endian crc, then the payload; the crc-16 (0x1021, zero seed) covers the
// header bytes and the payload but not the crc bytes.
// Output stream (m_*): m_tuser 0 is a payload byte, forwarded as it arrives;
// m_tuser 1 is the single status word of the buffer, with m_tlast set.
// Status: 0 ok, 1 bad start byte, 2 buffer too short, 3 crc mismatch. Payload
// should be dropped downstream unless the following status is ok.
// Config channel (cfg_*): start marker byte, always ready, reset value 90.
// Results are queued as their byte is accepted and leave on m_* in order.
// Throughput: one byte per cycle while s_tready is high; a byte that yields
// both its payload word and the status puts two words in the queue. s_tready
// comes from the fill of a three-word output queue, so it is high while at
// most one word is waiting. A stalled receiver fills the queue and then holds
// s_tready low. Reset clears the frame state and empties the queue; the start
// marker returns to 90.
module framed_packet_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        s_tlast,
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // payload_byte[7:0], frame_status[9:8],
                                   // frame_type[17:10], frame_length[33:18], zero
    output logic        m_tuser,   // item_kind[0]
    output logic        m_tlast
);

    logic [7:0]     marker_reg;
    logic           in_accept, pop, can_take;
    fpd_pkg::push_t push;
    fpd_pkg::item_t head;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid & can_take;
    assign s_tready  = can_take;
    assign pop       = m_tvalid & m_tready;

    // start marker register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= fpd_pkg::START_MARKER_RESET;
        end else if (cfg_valid) begin
            marker_reg <= cfg_data;
        end
    end

    fpd_frame_ctl u_ctl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .rx_byte      (s_tdata),
        .buffer_end   (s_tlast),
        .start_marker (marker_reg),
        .push         (push)
    );

    fpd_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (m_tvalid),
        .can_take   (can_take)
    );

    // result word packing
    assign m_tdata = {6'b000000, head.frame_length, head.frame_type,
                      head.frame_status, head.payload_byte};
    assign m_tuser = head.item_kind;
    assign m_tlast = head.final_item;

endmodule

@@ src/fpd_checker.sv @@
module fpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [7:0]  cfg_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a held result word stays offered
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // only status words end a run
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("tlast and kind disagree");

    // payload words carry a zero status
    a_payload_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[9:8] == 2'(fpd_pkg::ST_OK)))
        else $error("payload word with non-zero status");

    // output empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // input taken again once a stalled receiver drains two words
    a_ready_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tvalid && m_tready ##1 !s_tready && m_tvalid && m_tready
        |=> s_tready)
        else $error("input not released after output drained");

endmodule

bind framed_packet_decoder_top fpd_checker u_fpd_checker (.*);
